/* hw/rtl/dpnc_pkg.sv */
// Package for the diode pair Newton clipper: widths, fixed-point constants,
// controller commands and status. No dependencies.
package dpnc_pkg;

	// Fixed widths of the transaction fields.
	localparam int WaveW = 24;
	localparam int ParW  = 22;
	localparam int VoltW = 23;

	// Internal value width; values saturate at +-2^62.
	localparam int ValW = 64;

	// Euler's number in Q32.
	localparam logic [63:0] EQ32 = 64'd11674931555;

	// Datapath operations, one per micro step.
	localparam logic [4:0] OP_LOAD    = 5'd0;   // floor and clamp inputs
	localparam logic [4:0] OP_INVR    = 5'd1;   // inv_r = 1 / R
	localparam logic [4:0] OP_GVT     = 5'd2;   // g_vt = g / vt
	localparam logic [4:0] OP_N       = 5'd3;   // n = clamp(v / vt)
	localparam logic [4:0] OP_SPLIT   = 5'd4;   // k and r of |n|
	localparam logic [4:0] OP_TAYLOR  = 5'd5;   // one Taylor product
	localparam logic [4:0] OP_TDIV    = 5'd6;   // term / i
	localparam logic [4:0] OP_EMUL    = 5'd7;   // ep = ep * e
	localparam logic [4:0] OP_ESUM    = 5'd8;   // ep = ep * sum
	localparam logic [4:0] OP_EM      = 5'd9;   // em = ones / ep
	localparam logic [4:0] OP_HYP     = 5'd10;  // sinh and cosh
	localparam logic [4:0] OP_GSH     = 5'd11;  // g * sinh
	localparam logic [4:0] OP_AVR     = 5'd12;  // (a - v) / R
	localparam logic [4:0] OP_DF      = 5'd13;  // g_vt * cosh + inv_r
	localparam logic [4:0] OP_FDF     = 5'd14;  // f / df and update v
	localparam logic [4:0] OP_STORE   = 5'd15;  // latch result
	localparam logic [4:0] OP_NONE    = 5'd16;

	// Command from controller to datapath.
	typedef struct packed {
		logic       start;  // launch an operation this cycle
		logic [4:0] op;
	} dpnc_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic       done;    // the launched operation finished
		logic [3:0] k;       // integer part of |n|, capped at 12
	} dpnc_stat_t;

endpackage

/* hw/rtl/dpnc_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface dpnc_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/dpnc_div.sv */
// Iterative radix-2 divider: floor((num << s) / den), saturated at 2^62.
// Depends on dpnc_pkg.
module dpnc_div
	import dpnc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [63:0]     num,
	input  logic [6:0]      shift,
	input  logic [63:0]     den,
	output logic            done,
	output logic [63:0]     quo
);
	logic [127:0] dividend_q;
	logic [64:0]  rem_q;
	logic [63:0]  den_q;
	logic [63:0]  q_q;
	logic [7:0]   cnt_q;
	logic         busy_q;
	logic         ovf_q;
	logic [64:0]  rem_sh;
	logic         ge;

	// One quotient bit per cycle, most significant first.
	assign rem_sh = {rem_q[63:0], dividend_q[127]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 8'd127;
			end else if (busy_q) begin
				if (cnt_q == 8'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= {64'd0, num} << shift;
			rem_q      <= '0;
			den_q      <= den;
			q_q        <= '0;
			ovf_q      <= 1'b0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[126:0], 1'b0};
			if (ge) begin
				rem_q <= rem_sh - {1'b0, den_q};
				if (cnt_q[7:6] != 2'b00) begin
					ovf_q <= 1'b1;
				end else begin
					q_q[cnt_q[5:0]] <= 1'b1;
				end
			end else begin
				rem_q <= rem_sh;
			end
		end
	end

	assign quo = (ovf_q || q_q > 64'h4000_0000_0000_0000) ?
		64'h4000_0000_0000_0000 : q_q;
endmodule

/* hw/rtl/dpnc_datapath.sv */
// Datapath: operand registers, a sequential multiplier built from 32-bit partial
// products, and a shared iterative divider. Depends on dpnc_pkg, dpnc_div.
module dpnc_datapath
	import dpnc_pkg::*;
#(
	parameter int FRACTION_BITS = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dpnc_cmd_t              cmd,
	input  logic [3:0]             tidx,
	input  logic signed [WaveW-1:0] wave_in,
	input  logic [ParW-1:0]        res_in,
	input  logic [ParW-1:0]        str_in,
	input  logic [ParW-1:0]        vt_in,
	output dpnc_stat_t             stat,
	output logic [VoltW-1:0]       volt
);
	localparam int F = FRACTION_BITS;
	localparam logic [63:0] OneQ  = 64'd1 << F;
	localparam logic [63:0] RMin  = ((64'd4 << F) + 64'd50) / 64'd100;
	localparam logic [63:0] GMin  = ((64'd1 << F) + 64'd500) / 64'd1000;
	localparam logic [63:0] VtMin = ((64'd1 << F) + 64'd10) / 64'd20;
	localparam logic [63:0] ALim  = ((64'd28 << F) + 64'd5) / 64'd10;
	localparam logic [63:0] VLim  = 64'd2 << F;
	localparam logic [63:0] NLim  = 64'd11 << F;
	localparam logic [63:0] Sat   = 64'h4000_0000_0000_0000;
	localparam int          RecipShift = 37;

	// Operand and result registers.
	logic signed [63:0] a_q, v_q, n_q, sh_q, ch_q, f_q;
	logic [63:0] r_q, g_q, vt_q, invr_q, gvt_q;
	logic [63:0] frac_q, term_q, sum_q, ep_q, em_q;
	logic [3:0]  k_q;
	logic [4:0]  op_q;
	logic [VoltW-1:0] prev_q;

	// Multiplier: magnitude a*b over four 32x32 partial products.
	logic [63:0]  ma_q, mb_q;
	logic [6:0]   ms_q;
	logic [127:0] acc_q;
	logic [2:0]   mcnt_q;
	logic         mbusy_q, mdone_q;
	logic [63:0]  pp;
	logic [127:0] ppw;
	logic [127:0] mshift;
	logic [63:0]  mres;

	// Divider interface.
	logic         dstart;
	logic [63:0]  dnum, dden, dquo;
	logic [6:0]   dshift;
	logic         ddone;
	logic         dneg_q;

	// Helpers for magnitudes and signs.
	function automatic logic [63:0] fmag(input logic signed [63:0] x);
		fmag = x[63] ? 64'(-x) : 64'(x);
	endfunction
	function automatic logic signed [63:0] fsgn(input logic [63:0] m, input logic neg);
		fsgn = neg ? -$signed(m) : $signed(m);
	endfunction
	function automatic logic signed [63:0] fclamp(input logic signed [63:0] x,
			input logic [63:0] lim);
		if (x > $signed(lim)) fclamp = $signed(lim);
		else if (x < -$signed(lim)) fclamp = -$signed(lim);
		else fclamp = x;
	endfunction

	// Reciprocals ceil(2^37 / d) for the Taylor divisors 1 to 14. A Taylor term
	// never exceeds 2^33, so the product shifted right by 37 is the exact
	// floor of term / d.
	function automatic logic [63:0] frecip(input logic [3:0] d);
		case (d)
			4'd1:    frecip = 64'd137438953472;
			4'd2:    frecip = 64'd68719476736;
			4'd3:    frecip = 64'd45812984491;
			4'd4:    frecip = 64'd34359738368;
			4'd5:    frecip = 64'd27487790695;
			4'd6:    frecip = 64'd22906492246;
			4'd7:    frecip = 64'd19634136211;
			4'd8:    frecip = 64'd17179869184;
			4'd9:    frecip = 64'd15270994831;
			4'd10:   frecip = 64'd13743895348;
			4'd11:   frecip = 64'd12494450316;
			4'd12:   frecip = 64'd11453246123;
			4'd13:   frecip = 64'd10572227191;
			4'd14:   frecip = 64'd9817068106;
			default: frecip = 64'd0;
		endcase
	endfunction

	dpnc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.num    (dnum),
		.shift  (dshift),
		.den    (dden),
		.done   (ddone),
		.quo    (dquo)
	);

	logic is_div, is_mul, mstart;
	logic [63:0] mopa, mopb;
	logic [6:0]  mopshift;
	logic mneg;

	// Route each operation to the multiplier, divider or single-cycle logic.
	always_comb begin
		is_div   = 1'b0;
		is_mul   = 1'b0;
		dnum     = '0;
		dden     = 64'd1;
		dshift   = 7'(F);
		mopa     = '0;
		mopb     = '0;
		mopshift = 7'(F);
		mneg     = 1'b0;
		case (cmd.op)
			OP_INVR: begin
				is_div = 1'b1; dnum = OneQ; dden = r_q;
			end
			OP_GVT: begin
				is_div = 1'b1; dnum = g_q; dden = vt_q;
			end
			OP_N: begin
				is_div = 1'b1; dnum = fmag(v_q); dden = vt_q; mneg = v_q[63];
			end
			OP_TAYLOR: begin
				is_mul = 1'b1; mopa = term_q; mopb = frac_q; mopshift = 7'd32;
			end
			OP_TDIV: begin
				is_mul = 1'b1; mopa = term_q; mopb = frecip(tidx);
				mopshift = 7'(RecipShift);
			end
			OP_EMUL: begin
				is_mul = 1'b1; mopa = ep_q; mopb = EQ32; mopshift = 7'd32;
			end
			OP_ESUM: begin
				is_mul = 1'b1; mopa = ep_q; mopb = sum_q; mopshift = 7'd32;
			end
			OP_EM: begin
				is_div = 1'b1; dnum = 64'hFFFF_FFFF_FFFF_FFFF; dden = ep_q; dshift = 7'd0;
			end
			OP_GSH: begin
				is_mul = 1'b1; mopa = g_q; mopb = fmag(sh_q); mneg = sh_q[63];
			end
			OP_AVR: begin
				is_div = 1'b1; dnum = fmag(a_q - v_q); dden = r_q;
				mneg = a_q < v_q;
			end
			OP_DF: begin
				is_mul = 1'b1; mopa = gvt_q; mopb = fmag(ch_q); mneg = ch_q[63];
			end
			OP_FDF: begin
				is_div = 1'b1; dnum = fmag(f_q);
				dden = (fmag(sh_q) > Sat) ? Sat : fmag(sh_q);
				mneg = f_q[63] != sh_q[63];
			end
			default: ;
		endcase
	end

	assign dstart = cmd.start && is_div && !(cmd.op == OP_FDF && sh_q == 0);
	assign mstart = cmd.start && is_mul;

	// Partial product selection: cycle c picks half c[0] of a and half c[1] of b.
	assign pp = (mcnt_q[0] ? {32'd0, ma_q[63:32]} : {32'd0, ma_q[31:0]}) *
		(mcnt_q[1] ? {32'd0, mb_q[63:32]} : {32'd0, mb_q[31:0]});
	assign ppw = {64'd0, pp} << (7'(mcnt_q[0]) * 7'd32 + 7'(mcnt_q[1]) * 7'd32);
	assign mshift = acc_q >> ms_q;
	assign mres = (mshift > {64'd0, Sat}) ? Sat : mshift[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (mstart) begin
				mbusy_q <= 1'b1;
				mcnt_q  <= '0;
			end else if (mbusy_q) begin
				mcnt_q <= mcnt_q + 3'd1;
				if (mcnt_q == 3'd3) begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mstart) begin
			ma_q  <= mopa;
			mb_q  <= mopb;
			ms_q  <= mopshift;
			acc_q <= '0;
		end else if (mbusy_q) begin
			acc_q <= acc_q + ppw;
		end
	end

	// Sign and pending operation captured at launch.
	logic single_done_q;
	logic signed [63:0] qs, ms_s;
	logic [63:0] x_abs;
	logic [63:0] hsum, hdif;

	assign qs    = fsgn(dquo, dneg_q);
	assign ms_s  = fsgn(mres, dneg_q);
	assign x_abs = fmag(n_q);
	assign hsum  = ((ep_q + em_q) >> 1) >> (32 - F);
	assign hdif  = ((ep_q - em_q) >> 1) >> (32 - F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q          <= OP_NONE;
			dneg_q        <= 1'b0;
			single_done_q <= 1'b0;
			prev_q        <= '0;
		end else begin
			single_done_q <= 1'b0;
			if (cmd.start) begin
				op_q   <= cmd.op;
				dneg_q <= mneg;
				single_done_q <= !(is_mul || dstart);
			end
			if (single_done_q && op_q == OP_STORE) prev_q <= v_q[VoltW-1:0];
		end
	end

	// Single-cycle operations and write-back of unit results.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			case (cmd.op)
				OP_LOAD: begin
					a_q  <= fclamp(64'(wave_in), ALim);
					r_q  <= (64'(res_in) < RMin) ? RMin : 64'(res_in);
					g_q  <= (64'(str_in) < GMin) ? GMin : 64'(str_in);
					vt_q <= (64'(vt_in) < VtMin) ? VtMin : 64'(vt_in);
					v_q  <= fclamp(64'(signed'(prev_q)), VLim);
				end
				OP_SPLIT: begin
					k_q    <= (x_abs >> F) > 64'd12 ? 4'd12 : 4'(x_abs >> F);
					frac_q <= (x_abs & (OneQ - 64'd1)) << (32 - F);
					term_q <= 64'd1 << 32;
					sum_q  <= 64'd1 << 32;
					ep_q   <= 64'd1 << 32;
				end
				OP_HYP: begin
					sh_q <= fsgn(hdif, n_q[63]);
					ch_q <= $signed(hsum);
				end
				OP_FDF: if (sh_q == 0) v_q <= fclamp(v_q, VLim);
				default: ;
			endcase
		end
		if (ddone) begin
			case (op_q)
				OP_INVR: invr_q <= dquo;
				OP_GVT:  gvt_q  <= dquo;
				OP_N:    n_q    <= fclamp(qs, NLim);
				OP_EM:   em_q   <= dquo;
				OP_AVR:  f_q    <= f_q - qs;
				OP_FDF:  v_q    <= fclamp(v_q - qs, VLim);
				default: ;
			endcase
		end
		if (mdone_q) begin
			case (op_q)
				OP_TAYLOR: term_q <= mres;
				OP_TDIV: begin
					term_q <= mres;
					sum_q  <= sum_q + mres;
				end
				OP_EMUL:   ep_q   <= mres;
				OP_ESUM:   ep_q   <= mres;
				OP_GSH:    f_q    <= ms_s;
				OP_DF:     sh_q   <= ms_s + $signed(invr_q);
				default: ;
			endcase
		end
	end

	assign stat.done = ddone || mdone_q || single_done_q;
	assign stat.k    = k_q;
	assign volt      = prev_q;
endmodule

/* hw/rtl/dpnc_ctrl.sv */
// Controller: sequences the datapath operations of one transaction.
// Depends on dpnc_pkg.
module dpnc_ctrl
	import dpnc_pkg::*;
#(
	parameter int NEWTON_STEPS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dpnc_stat_t stat,
	output dpnc_cmd_t  cmd,
	output logic [3:0] tidx
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LAUNCH = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;

	logic [1:0] state_q;
	logic [4:0] op_q;
	logic [3:0] i_q;
	logic [3:0] e_q;
	logic [4:0] step_q;
	logic       outv_q;
	logic [4:0] nxt_op;

	// Next operation after op_q completes.
	always_comb begin
		nxt_op = OP_NONE;
		case (op_q)
			OP_LOAD:   nxt_op = OP_INVR;
			OP_INVR:   nxt_op = OP_GVT;
			OP_GVT:    nxt_op = OP_N;
			OP_N:      nxt_op = OP_SPLIT;
			OP_SPLIT:  nxt_op = OP_TAYLOR;
			OP_TAYLOR: nxt_op = OP_TDIV;
			OP_TDIV:   nxt_op = (i_q == 4'd14) ? ((stat.k != 0) ? OP_EMUL : OP_ESUM) : OP_TAYLOR;
			OP_EMUL:   nxt_op = (e_q + 4'd1 >= stat.k) ? OP_ESUM : OP_EMUL;
			OP_ESUM:   nxt_op = OP_EM;
			OP_EM:     nxt_op = OP_HYP;
			OP_HYP:    nxt_op = OP_GSH;
			OP_GSH:    nxt_op = OP_AVR;
			OP_AVR:    nxt_op = OP_DF;
			OP_DF:     nxt_op = OP_FDF;
			OP_FDF:    nxt_op = (step_q + 5'd1 == 5'(NEWTON_STEPS)) ? OP_STORE : OP_N;
			default:   nxt_op = OP_NONE;
		endcase
	end

	assign in_ready  = state_q == S_IDLE && !outv_q;
	assign out_valid = outv_q;
	assign cmd.start = state_q == S_LAUNCH || (state_q == S_IDLE && in_valid && !outv_q);
	assign cmd.op    = (state_q == S_IDLE) ? OP_LOAD : op_q;
	assign tidx      = i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_LOAD;
			i_q     <= '0;
			e_q     <= '0;
			step_q  <= '0;
			outv_q  <= 1'b0;
		end else begin
			if (outv_q && out_ready) outv_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && !outv_q) begin
					op_q    <= OP_LOAD;
					step_q  <= '0;
					state_q <= S_WAIT;
				end
				S_LAUNCH: state_q <= S_WAIT;
				S_WAIT: if (stat.done) begin
					case (op_q)
						OP_SPLIT: begin i_q <= 4'd1; e_q <= '0; end
						OP_TDIV:  i_q <= i_q + 4'd1;
						OP_EMUL:  e_q <= e_q + 4'd1;
						OP_FDF:   step_q <= step_q + 5'd1;
						default: ;
					endcase
					if (op_q == OP_STORE) begin
						outv_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						op_q    <= nxt_op;
						state_q <= S_LAUNCH;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hw/rtl/diode_pair_newton_clipper.sv */
// Antiparallel diode pair solved by Newton iteration; one transaction in, one
// out. The time to a result is set mainly by eighteen divisions on the shared
// bit-serial divider; Taylor divisions run on the multiplier, and the number
// of multiplies grows with the integer part of |v/vt| (at most 11) in each
// Newton step. The next input is taken no earlier than the cycle after the
// result has been taken. Depends on dpnc_pkg, dpnc_if, dpnc_ctrl, dpnc_datapath.
module diode_pair_newton_clipper
	import dpnc_pkg::*;
#(
	parameter int NEWTON_STEPS  = 4,
	parameter int FRACTION_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	dpnc_if.sink   in_ch,
	dpnc_if.source out_ch
);
	dpnc_cmd_t  cmd;
	dpnc_stat_t stat;
	logic [3:0] tidx;
	logic [VoltW-1:0] volt;

	// Input payload: wave, resistance, strength, thermal voltage, msb first.
	dpnc_ctrl #(.NEWTON_STEPS(NEWTON_STEPS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd),
		.tidx      (tidx)
	);

	dpnc_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.tidx    (tidx),
		.wave_in (in_ch.data[89:66]),
		.res_in  (in_ch.data[65:44]),
		.str_in  (in_ch.data[43:22]),
		.vt_in   (in_ch.data[21:0]),
		.stat    (stat),
		.volt    (volt)
	);

	assign out_ch.data = volt;
endmodule

/* tb/tb_diode_pair_newton_clipper.sv */
// Self-checking testbench for diode_pair_newton_clipper: drives wave and parameter
// transactions and checks each solved voltage against a local Newton solver.
// Depends on dpnc_pkg, dpnc_if and the clipper RTL.
module tb_diode_pair_newton_clipper
	import dpnc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 20;
	localparam int STEPS = 4;
	localparam int InW = WaveW + 3 * ParW;
	localparam longint ONE_Q = longint'(1) << FB;
	localparam longint R_FLOOR = ((longint'(4) << FB) + 50) / 100;
	localparam longint G_FLOOR = ((longint'(1) << FB) + 500) / 1000;
	localparam longint VT_FLOOR = ((longint'(1) << FB) + 10) / 20;
	localparam longint WAVE_LIM = ((longint'(28) << FB) + 5) / 10;
	localparam longint VOLT_LIM = longint'(2) << FB;
	localparam longint EXP_LIM = longint'(11) << FB;
	localparam logic [63:0] SAT = 64'd1 << 62;
	localparam longint CYCLE_LIMIT = 40_000_000;

	logic clk;
	logic arst_n;
	logic quiet;
	longint cycles;
	int errors;
	int sent;
	int checked;
	longint volt_state;
	logic [VoltW-1:0] expected_voltage[$];

	dpnc_if #(.W(InW)) in_ch ();
	dpnc_if #(.W(VoltW)) out_ch ();

	diode_pair_newton_clipper #(.NEWTON_STEPS(STEPS), .FRACTION_BITS(FB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Fixed-point helpers: unsigned magnitudes with saturation at 2^62.
	function automatic logic [63:0] umul_shr(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> s;
		if (p[127:64] != 0)
			return SAT;
		return (p[63:0] > SAT) ? SAT : p[63:0];
	endfunction

	function automatic logic [63:0] udiv_shl(logic [63:0] num, int s, logic [63:0] den);
		logic [127:0] q;
		q = ({64'd0, num} << s) / {64'd0, den};
		return (q > {64'd0, SAT}) ? SAT : q[63:0];
	endfunction

	function automatic logic [63:0] magn(longint x);
		logic [63:0] u;
		u = x;
		return (x < 0) ? (~u + 64'd1) : u;
	endfunction

	function automatic longint signed_of(logic [63:0] m, logic neg);
		longint r;
		r = m;
		return neg ? -r : r;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return signed_of(umul_shr(magn(a), magn(b), FB), (a < 0) != (b < 0));
	endfunction

	function automatic longint fx_div(longint a, longint b);
		logic [63:0] d;
		d = magn(b);
		if (d == 0)
			return 0;
		if (d > SAT)
			d = SAT;
		return signed_of(udiv_shl(magn(a), FB, d), (a < 0) != (b < 0));
	endfunction

	function automatic longint clamp_sym(longint x, longint lim);
		return (x > lim) ? lim : ((x < -lim) ? -lim : x);
	endfunction

	// sinh and cosh of n, built from e^|n| in Q32.
	task automatic hyperbolics(input longint n, output longint sh, output longint ch);
		logic [63:0] x, k, r, ep, em, term, sum;
		x = magn(n);
		k = x >> FB;
		r = (x & ((64'd1 << FB) - 1)) << (32 - FB);
		ep = 64'd1 << 32;
		term = 64'd1 << 32;
		sum = 64'd1 << 32;
		for (int i = 1; i <= 14; i++) begin
			term = ((term * r) >> 32) / i;
			sum += term;
		end
		for (int i = 0; i < k && i < 12; i++)
			ep = umul_shr(ep, EQ32, 32);
		ep = umul_shr(ep, sum, 32);
		em = 64'hFFFF_FFFF_FFFF_FFFF / ep;
		sh = signed_of(((ep - em) >> 1) >> (32 - FB), n < 0);
		ch = longint'(((ep + em) >> 1) >> (32 - FB));
	endtask

	// Solve one diode voltage and update the stored voltage.
	task automatic predict_diode_voltage(input logic [InW-1:0] item);
		longint a, rp, g, vt, v, inv_r, g_vt, n, sh, ch, f, df;
		a = longint'($signed(item[InW-1 -: WaveW]));
		rp = longint'(item[3*ParW-1 -: ParW]);
		g = longint'(item[2*ParW-1 -: ParW]);
		vt = longint'(item[ParW-1:0]);
		if (rp < R_FLOOR)
			rp = R_FLOOR;
		if (g < G_FLOOR)
			g = G_FLOOR;
		if (vt < VT_FLOOR)
			vt = VT_FLOOR;
		a = clamp_sym(a, WAVE_LIM);
		v = clamp_sym(volt_state, VOLT_LIM);
		inv_r = fx_div(ONE_Q, rp);
		g_vt = fx_div(g, vt);
		for (int s = 0; s < STEPS; s++) begin
			n = clamp_sym(fx_div(v, vt), EXP_LIM);
			hyperbolics(n, sh, ch);
			f = fx_mul(g, sh) - fx_div(a - v, rp);
			df = fx_mul(g_vt, ch) + inv_r;
			v = clamp_sym(v - fx_div(f, df), VOLT_LIM);
		end
		volt_state = v;
		expected_voltage.push_back(v[VoltW-1:0]);
	endtask

	task automatic report(input string what, input logic [VoltW-1:0] got,
			input logic [VoltW-1:0] want);
		errors++;
		$display("mismatch %s: diode_voltage got %0d expected %0d", what,
			$signed(got), $signed(want));
	endtask

	// Send one transaction; random idle bursts precede it unless quiet.
	task automatic send_item(input logic [WaveW-1:0] wave, input logic [ParW-1:0] res,
			input logic [ParW-1:0] strength, input logic [ParW-1:0] thermal);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = {wave, res, strength, thermal};
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_diode_voltage(in_ch.data);
		sent++;
		@(negedge clk);
	endtask

	// Output side stalls in random bursts.
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 5) - 1) @(negedge clk);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_voltage.size() == 0) begin
				errors++;
				$display("unexpected result transaction: %0d", $signed(out_ch.data));
			end else begin
				if (out_ch.data !== expected_voltage[0])
					report("voltage", out_ch.data, expected_voltage[0]);
				void'(expected_voltage.pop_front());
				checked++;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Field extremes and floors of every parameter.
	task automatic test_extremes();
		send_item(24'h7FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF);
		send_item(24'h800000, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF);
		send_item(24'h000000, 22'h0, 22'h0, 22'h0);
		send_item(24'h7FFFFF, 22'h0, 22'h0, 22'h0);
		send_item(24'h800000, 22'h0, 22'h0, 22'h0);
		send_item(24'h7FFFFF, 22'h3FFFFF, 22'h0, 22'h0);
		send_item(24'h800000, 22'h0, 22'h3FFFFF, 22'h0);
		send_item(24'h400000, 22'h0, 22'h0, 22'h3FFFFF);
		send_item(24'hC00000, 22'h3FFFFF, 22'h3FFFFF, 22'h0);
	endtask

	// Wave clamp boundary, floor boundaries and a saturating exponent.
	task automatic test_clamps();
		send_item(24'(WAVE_LIM), 22'(R_FLOOR), 22'(G_FLOOR), 22'(VT_FLOOR));
		send_item(24'(WAVE_LIM + 1), 22'(R_FLOOR - 1), 22'(G_FLOOR - 1), 22'(VT_FLOOR - 1));
		send_item(24'(-WAVE_LIM - 1), 22'(R_FLOOR + 1), 22'(G_FLOOR + 1), 22'(VT_FLOOR + 1));
		send_item(24'(-WAVE_LIM), 22'd1048576, 22'd1049, 22'd52429);
		send_item(24'd1048576, 22'd1048576, 22'd10, 22'd26214);
		send_item(24'd0, 22'd1048576, 22'd1048, 22'd26214);
		send_item(24'hF00000, 22'd4000, 22'd100, 22'd1000);
		send_item(24'd2097152, 22'd3000000, 22'd1, 22'd4000000);
		send_item(24'd0, 22'd100000, 22'd2000, 22'd30000);
	endtask

	// Audio-like sequence: a slowly swinging wave with plausible parameters.
	task automatic test_random_audio(input int count);
		longint w;
		w = 0;
		for (int i = 0; i < count; i++) begin
			w = clamp_sym(w + $signed($urandom_range(0, 600000)) - 300000, 3500000);
			send_item(24'(w), 22'($urandom_range(20000, 2000000)),
				22'($urandom_range(500, 60000)), 22'($urandom_range(20000, 200000)));
		end
	endtask

	// Arbitrary field values across the full ranges.
	task automatic test_random_full(input int count);
		for (int i = 0; i < count; i++)
			send_item(24'($urandom), 22'($urandom), 22'($urandom), 22'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		quiet = 1'b0;
		cycles = 0;
		errors = 0;
		sent = 0;
		checked = 0;
		volt_state = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_clamps();
		test_random_audio(1100);
		test_random_full(350);
		quiet = 1'b1;
		test_random_audio(100);
		test_random_full(50);
		in_ch.valid = 1'b0;
		wait (expected_voltage.size() == 0);
		repeat (50) @(posedge clk);
		$display("Covered %0d transactions: field extremes, floors, clamps, audio-like", sent);
		$display("sweeps and full-range values; %0d results checked.", checked);
		if (errors == 0 && expected_voltage.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
